// ===== sv/pcct_pkg.sv =====
package pcct_pkg;

   // item opcodes
   localparam logic OP_REGISTER = 1'b0;
   localparam logic OP_PACKET   = 1'b1;

   // result status codes
   localparam int unsigned STATUS_W = 3;
   typedef logic [STATUS_W-1:0] status_type;

   localparam status_type ST_TAKEN   = 3'd0;
   localparam status_type ST_UNKNOWN = 3'd1;
   localparam status_type ST_RANGE   = 3'd2;
   localparam status_type ST_REG     = 3'd3;
   localparam status_type ST_REJECT  = 3'd4;

endpackage

// ===== sv/pcct_div.sv =====
module pcct_div #(
   parameter int unsigned W = 13
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   input  logic [W-1:0] dividend,
   input  logic [W-1:0] divisor,
   output logic         done,
   output logic [W-1:0] quotient,
   output logic [W-1:0] remainder
);
   import pcct_pkg::*;

   localparam int unsigned CNT_W = $clog2(W + 1);

   logic [W-1:0]     quo_ff, quo_in;
   logic [W-1:0]     rem_ff, rem_in;
   logic [W-1:0]     dsr_ff, dsr_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             run_ff, run_in;
   logic             done_ff, done_in;

   logic [W:0] rem_sh;
   logic [W:0] diff;

   // restoring division, one quotient bit per cycle
   always_comb begin
      rem_sh  = {rem_ff, quo_ff[W-1]};
      diff    = rem_sh - {1'b0, dsr_ff};
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      if (start) begin
         quo_in = dividend;
         rem_in = '0;
         dsr_in = divisor;
         cnt_in = '0;
         run_in = 1'b1;
      end else if (run_ff) begin
         if (!diff[W]) begin
            rem_in = diff[W-1:0];
            quo_in = {quo_ff[W-2:0], 1'b1};
         end else begin
            rem_in = rem_sh[W-1:0];
            quo_in = {quo_ff[W-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(W - 1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
   end

   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule

// ===== sv/packet_chunk_completion_tracker.sv =====
// Packet chunk completion tracker. Items enter on start while busy is low;
// each item gives exactly one result, shown for one cycle with rsp_valid
// high, and the receiver cannot stall it. One item is worked at a time.
// A packet item passes the accept cycle, the one-bit-per-cycle divider
// (offset / chunk size over the 13-bit width of the count fields, then its
// registered done flag), the synchronous reads of the received-bit and
// fill-count memories and then the update and write back. A registration
// runs the ceiling division and then clears the slot's region of both
// memories, one entry per cycle. Rejected items (unknown slot, offset out
// of range, zero chunk size, packet total above MAX_PACKETS) answer in the
// cycle after they are accepted. busy covers the whole item, so memory
// accesses of two items never overlap.
// Memory contents need no clearing after reset: a slot is read only after
// its registration has swept its region.
module packet_chunk_completion_tracker #(
   parameter int unsigned MSG_SLOTS   = 16,
   parameter int unsigned MAX_PACKETS = 4096
) (
   input  logic                                         clock,
   input  logic                                         reset,
   input  logic                                         start,
   output logic                                         busy,
   input  logic                                         req_op,
   input  logic [((MSG_SLOTS > 1) ? $clog2(MSG_SLOTS) : 1)-1:0] req_msg_slot,
   input  logic [$clog2(MAX_PACKETS)-1:0]               req_packet_offset,
   input  logic [$clog2(MAX_PACKETS):0]                 req_total_packets_in,
   input  logic [$clog2(MAX_PACKETS):0]                 req_chunk_size_in,
   output logic                                         rsp_valid,
   output pcct_pkg::status_type                         rsp_status,
   output logic [((MSG_SLOTS > 1) ? $clog2(MSG_SLOTS) : 1)-1:0] rsp_echo_slot,
   output logic                                         rsp_chunk_done,
   output logic [$clog2(MAX_PACKETS)-1:0]               rsp_chunk_index,
   output logic                                         rsp_message_done
);
   import pcct_pkg::*;

   localparam int unsigned SLOT_W    = (MSG_SLOTS > 1) ? $clog2(MSG_SLOTS) : 1;
   localparam int unsigned OFF_W     = $clog2(MAX_PACKETS);
   localparam int unsigned CNT_W     = OFF_W + 1;
   localparam int unsigned ADDR_W    = SLOT_W + OFF_W;
   localparam int unsigned MEM_DEPTH = 1 << ADDR_W;

   // sequencer states
   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_DIV  = 3'd1;
   localparam logic [2:0] S_READ = 3'd2;
   localparam logic [2:0] S_UPD  = 3'd3;
   localparam logic [2:0] S_CLR  = 3'd4;

   logic [2:0] state_ff, state_in;

   // item held for the duration of its work
   logic              op_ff, op_in;
   logic [SLOT_W-1:0] slot_ff, slot_in;
   logic [OFF_W-1:0]  off_ff, off_in;
   logic [CNT_W-1:0]  total_ff, total_in;
   logic [CNT_W-1:0]  csize_ff, csize_in;
   logic [OFF_W-1:0]  chunk_ff, chunk_in;
   logic [CNT_W-1:0]  len_ff, len_in;
   logic [CNT_W-1:0]  clr_ff, clr_in;

   // per-slot table, small enough for flops
   logic [MSG_SLOTS-1:0] valid_ff;
   logic [CNT_W-1:0]     tot_tab_ff   [MSG_SLOTS];
   logic [CNT_W-1:0]     csz_tab_ff   [MSG_SLOTS];
   logic [CNT_W-1:0]     ctot_tab_ff  [MSG_SLOTS];
   logic [CNT_W-1:0]     fin_tab_ff   [MSG_SLOTS];
   logic                 tab_reg_we;
   logic                 tab_fin_we;
   logic [CNT_W-1:0]     tab_ctot_wd;
   logic [CNT_W-1:0]     tab_fin_wd;

   // received bits and chunk fill counts, addressed {slot, index}
   logic             bits_mem [MEM_DEPTH];
   logic [CNT_W-1:0] fill_mem [MEM_DEPTH];
   logic             bits_we;
   logic             bits_wd;
   logic [ADDR_W-1:0] bits_addr;
   logic             fill_we;
   logic [CNT_W-1:0] fill_wd;
   logic [ADDR_W-1:0] fill_addr;
   logic             bit_rd_ff;
   logic [CNT_W-1:0] fill_rd_ff;

   // result register
   logic             rsp_valid_ff, rsp_valid_in;
   status_type       rsp_status_ff, rsp_status_in;
   logic [SLOT_W-1:0] rsp_slot_ff, rsp_slot_in;
   logic             rsp_cdone_ff, rsp_cdone_in;
   logic [OFF_W-1:0] rsp_cidx_ff, rsp_cidx_in;
   logic             rsp_mdone_ff, rsp_mdone_in;

   // divider
   logic             div_start;
   logic [CNT_W-1:0] div_dividend;
   logic             div_done;
   logic [CNT_W-1:0] div_quo;
   logic [CNT_W-1:0] div_rem;

   logic             accept;
   logic             slot_in_range;
   logic             slot_known;
   logic [CNT_W-1:0] chunk_base;
   logic [CNT_W-1:0] len_raw;
   logic [CNT_W-1:0] fill_new;
   logic             cdone;
   logic [CNT_W-1:0] fin_new;

   assign accept        = start && (state_ff == S_IDLE);
   assign slot_in_range = (32'(req_msg_slot) < MSG_SLOTS);
   assign slot_known    = slot_in_range && valid_ff[req_msg_slot];
   assign div_dividend  = (req_op == OP_PACKET) ? {1'b0, req_packet_offset}
                                                : req_total_packets_in;

   // first packet of the chunk sits at off - (off mod csize)
   assign chunk_base = {1'b0, off_ff} - div_rem;
   assign len_raw    = total_ff - chunk_base;

   assign fill_new = fill_rd_ff + 1'b1;
   assign cdone    = !bit_rd_ff && (fill_new == len_ff);
   assign fin_new  = fin_tab_ff[slot_ff] + CNT_W'(cdone);

   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      slot_in       = slot_ff;
      off_in        = off_ff;
      total_in      = total_ff;
      csize_in      = csize_ff;
      chunk_in      = chunk_ff;
      len_in        = len_ff;
      clr_in        = clr_ff;
      div_start     = 1'b0;
      tab_reg_we    = 1'b0;
      tab_fin_we    = 1'b0;
      tab_ctot_wd   = div_quo + CNT_W'(div_rem != '0);
      tab_fin_wd    = fin_new;
      bits_we       = 1'b0;
      bits_wd       = 1'b0;
      bits_addr     = {slot_ff, off_ff};
      fill_we       = 1'b0;
      fill_wd       = fill_new;
      fill_addr     = {slot_ff, chunk_ff};
      rsp_valid_in  = 1'b0;
      rsp_status_in = rsp_status_ff;
      rsp_slot_in   = rsp_slot_ff;
      rsp_cdone_in  = 1'b0;
      rsp_cidx_in   = '0;
      rsp_mdone_in  = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               op_in       = req_op;
               slot_in     = req_msg_slot;
               off_in      = req_packet_offset;
               total_in    = req_total_packets_in;
               csize_in    = req_chunk_size_in;
               rsp_slot_in = req_msg_slot;
               if (req_op == OP_REGISTER) begin
                  if (!slot_in_range || req_chunk_size_in == '0 ||
                      32'(req_total_packets_in) > MAX_PACKETS) begin
                     rsp_valid_in  = 1'b1;
                     rsp_status_in = ST_REJECT;
                  end else begin
                     div_start = 1'b1;
                     state_in  = S_DIV;
                  end
               end else if (!slot_known) begin
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = ST_UNKNOWN;
               end else if ({1'b0, req_packet_offset} >= tot_tab_ff[req_msg_slot]) begin
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = ST_RANGE;
               end else begin
                  csize_in  = csz_tab_ff[req_msg_slot];
                  total_in  = tot_tab_ff[req_msg_slot];
                  div_start = 1'b1;
                  state_in  = S_DIV;
               end
            end
         end
         S_DIV: begin
            if (div_done) begin
               if (op_ff == OP_REGISTER) begin
                  tab_reg_we = 1'b1;
                  clr_in     = '0;
                  state_in   = S_CLR;
               end else begin
                  chunk_in = div_quo[OFF_W-1:0];
                  state_in = S_READ;
               end
            end
         end
         S_READ: begin
            // memory reads issue this cycle
            len_in   = (len_raw > csize_ff) ? csize_ff : len_raw;
            state_in = S_UPD;
         end
         S_UPD: begin
            if (!bit_rd_ff) begin
               bits_we = 1'b1;
               bits_wd = 1'b1;
               fill_we = 1'b1;
            end
            tab_fin_we    = cdone;
            rsp_valid_in  = 1'b1;
            rsp_status_in = ST_TAKEN;
            rsp_cdone_in  = cdone;
            rsp_cidx_in   = chunk_ff;
            rsp_mdone_in  = (fin_new == ctot_tab_ff[slot_ff]);
            state_in      = S_IDLE;
         end
         S_CLR: begin
            bits_we   = 1'b1;
            bits_wd   = 1'b0;
            bits_addr = {slot_ff, clr_ff[OFF_W-1:0]};
            fill_we   = 1'b1;
            fill_wd   = '0;
            fill_addr = {slot_ff, clr_ff[OFF_W-1:0]};
            clr_in    = clr_ff + 1'b1;
            if (clr_ff == CNT_W'(MAX_PACKETS - 1)) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = ST_REG;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   pcct_div #(
      .W (CNT_W)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_dividend),
      .divisor   (div_start ? ((req_op == OP_PACKET) ? csz_tab_ff[req_msg_slot]
                                                     : req_chunk_size_in)
                            : csize_ff),
      .done      (div_done),
      .quotient  (div_quo),
      .remainder (div_rem)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         valid_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (tab_reg_we) begin
            valid_ff[slot_ff] <= 1'b1;
         end
      end
      op_ff         <= op_in;
      slot_ff       <= slot_in;
      off_ff        <= off_in;
      total_ff      <= total_in;
      csize_ff      <= csize_in;
      chunk_ff      <= chunk_in;
      len_ff        <= len_in;
      clr_ff        <= clr_in;
      rsp_status_ff <= rsp_status_in;
      rsp_slot_ff   <= rsp_slot_in;
      rsp_cdone_ff  <= rsp_cdone_in;
      rsp_cidx_ff   <= rsp_cidx_in;
      rsp_mdone_ff  <= rsp_mdone_in;
   end

   // slot table writes
   always_ff @(posedge clock) begin
      if (tab_reg_we) begin
         tot_tab_ff[slot_ff]  <= total_ff;
         csz_tab_ff[slot_ff]  <= csize_ff;
         ctot_tab_ff[slot_ff] <= tab_ctot_wd;
         fin_tab_ff[slot_ff]  <= '0;
      end else if (tab_fin_we) begin
         fin_tab_ff[slot_ff]  <= tab_fin_wd;
      end
   end

   // received-bit memory
   always_ff @(posedge clock) begin
      if (bits_we) begin
         bits_mem[bits_addr] <= bits_wd;
      end
      bit_rd_ff <= bits_mem[bits_addr];
   end

   // chunk fill-count memory
   always_ff @(posedge clock) begin
      if (fill_we) begin
         fill_mem[fill_addr] <= fill_wd;
      end
      fill_rd_ff <= fill_mem[fill_addr];
   end

   assign busy             = (state_ff != S_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_echo_slot    = rsp_slot_ff;
   assign rsp_chunk_done   = rsp_cdone_ff;
   assign rsp_chunk_index  = rsp_cidx_ff;
   assign rsp_message_done = rsp_mdone_ff;

`ifndef SYNTHESIS
   // every result closes an item that was in work
   a_rsp_after_item: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ($past(busy) || $past(start)))
      else $error("result without an item in work");

   // a result shows only once its item has released busy
   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result while an item is in work");

   // non-packet results carry no chunk information
   a_rsp_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != ST_TAKEN) |->
         (!rsp_chunk_done && !rsp_message_done && rsp_chunk_index == '0))
      else $error("chunk fields set on a non-packet result");

   // the clearing sweep runs to its end before a new item
   a_clr_run: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CLR && clr_ff != CNT_W'(MAX_PACKETS - 1)) |=> (state_ff == S_CLR))
      else $error("clearing sweep cut short");
`endif

endmodule
